FILE: rtl/core/psf_pkg.sv
`timescale 1ns / 1ps
package psf_pkg;
  localparam int GlyphAw = 12;
  localparam int GlyphDepth = 4096;
  localparam int TableAw = 16;
  localparam int TableDepth = 65536;
  localparam int MaxW = 8;
  localparam int MaxH = 8;

  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_TABLE = 2'd1;
  localparam logic [1:0] KIND_DRAW = 2'd2;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  localparam logic [2:0] REG_WIDTH = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_BPG = 3'd2;
  localparam logic [2:0] REG_COUNT = 3'd3;
  localparam logic [2:0] REG_LINE = 3'd4;
  localparam logic [2:0] REG_FG = 3'd5;
  localparam logic [2:0] REG_BG = 3'd6;
  localparam logic [2:0] REG_UNI = 3'd7;

  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] glyph_byte_addr;
    logic [7:0]  data_byte;
    logic [15:0] char_code;
    logic [7:0]  cell_x;
    logic [7:0]  cell_y;
  } in_word_t;

  typedef struct packed {
    logic [25:0] pixel_offset;
    logic [31:0] pixel_value;
    logic        last_pixel;
  } out_word_t;

  typedef struct packed {
    logic [3:0]  glyph_width;
    logic [3:0]  glyph_height;
    logic [3:0]  bytes_per_glyph;
    logic [9:0]  glyph_count;
    logic [14:0] line_bytes;
    logic [31:0] fg_color;
    logic [31:0] bg_color;
    logic        unicode_enable;
  } cfg_t;
endpackage

FILE: rtl/core/psf_ram.sv
`timescale 1ns / 1ps
module psf_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/core/psf_regs.sv
`timescale 1ns / 1ps
module psf_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_psel,
  input  logic           cfg_penable,
  input  logic           cfg_pwrite,
  input  logic [4:0]     cfg_paddr,
  input  logic [31:0]    cfg_pwdata,
  output logic [31:0]    cfg_prdata,
  output logic           cfg_pready,
  output psf_pkg::cfg_t  cfg
);
  psf_pkg::cfg_t cfg_r;
  logic [2:0] idx;
  assign idx = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign cfg = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.glyph_width <= 4'd8;
      cfg_r.glyph_height <= 4'd8;
      cfg_r.bytes_per_glyph <= 4'd8;
      cfg_r.glyph_count <= 10'd256;
      cfg_r.line_bytes <= 15'd800;
      cfg_r.fg_color <= 32'h00FF_FFFF;
      cfg_r.bg_color <= 32'd0;
      cfg_r.unicode_enable <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (idx)
        psf_pkg::REG_WIDTH:  cfg_r.glyph_width <= cfg_pwdata[3:0];
        psf_pkg::REG_HEIGHT: cfg_r.glyph_height <= cfg_pwdata[3:0];
        psf_pkg::REG_BPG:    cfg_r.bytes_per_glyph <= cfg_pwdata[3:0];
        psf_pkg::REG_COUNT:  cfg_r.glyph_count <= cfg_pwdata[9:0];
        psf_pkg::REG_LINE:   cfg_r.line_bytes <= cfg_pwdata[14:0];
        psf_pkg::REG_FG:     cfg_r.fg_color <= cfg_pwdata;
        psf_pkg::REG_BG:     cfg_r.bg_color <= cfg_pwdata;
        psf_pkg::REG_UNI:    cfg_r.unicode_enable <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      psf_pkg::REG_WIDTH:  cfg_prdata = {28'd0, cfg_r.glyph_width};
      psf_pkg::REG_HEIGHT: cfg_prdata = {28'd0, cfg_r.glyph_height};
      psf_pkg::REG_BPG:    cfg_prdata = {28'd0, cfg_r.bytes_per_glyph};
      psf_pkg::REG_COUNT:  cfg_prdata = {22'd0, cfg_r.glyph_count};
      psf_pkg::REG_LINE:   cfg_prdata = {17'd0, cfg_r.line_bytes};
      psf_pkg::REG_FG:     cfg_prdata = cfg_r.fg_color;
      psf_pkg::REG_BG:     cfg_prdata = cfg_r.bg_color;
      psf_pkg::REG_UNI:    cfg_prdata = {31'd0, cfg_r.unicode_enable};
      default:             cfg_prdata = 32'd0;
    endcase
  end
endmodule

FILE: rtl/core/psf_glyph_renderer_top.sv
`timescale 1ns / 1ps
// Load and table words do not hold the input once taken; the table stays unavailable
// after reset while a clearing pass zeroes it, one entry a cycle.
// A draw runs its setup steps (table read, index check, products, origin), then
// per row one store read and w pixel words, one a cycle while out_stall is low.
// A draw of nonzero size stalls the input until its last pixel word is taken.
// Reset is synchronous, active low, and restores registers and decoder state.
module psf_glyph_renderer_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  psf_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output psf_pkg::out_word_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  psf_pkg::cfg_t cfg;
  psf_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg
  );

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_TRD   = 8'b0000_0100,
    S_IDX   = 8'b0000_1000,
    S_MUL   = 8'b0001_0000,
    S_ORG   = 8'b0010_0000,
    S_ROW   = 8'b0100_0000,
    S_PIX   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic [15:0] clr_r;
  logic [8:0]  gcnt_r;
  logic [15:0] acc_r;
  logic [1:0]  pend_r;
  psf_pkg::in_word_t item_r;
  logic [3:0]  w_r, h_r;
  logic [9:0]  idx_r;
  logic [11:0] base_r;
  logic [25:0] p1_r, p2_r, off_r, rowoff_r;
  logic [2:0]  x_r, y_r;
  logic [7:0]  row_r;
  logic        rowv_r;

  // table RAM
  logic        t_we;
  logic [15:0] t_wa, t_ra;
  logic [8:0]  t_wd, t_rd;
  psf_ram #(.Width(9), .Depth(psf_pkg::TableDepth)) u_table (
    .clk, .we(t_we), .waddr(t_wa), .wdata(t_wd), .raddr(t_ra), .rdata(t_rd)
  );
  // glyph store
  logic        g_we;
  logic [11:0] g_ra;
  logic [7:0]  g_rd;
  psf_ram #(.Width(8), .Depth(psf_pkg::GlyphDepth)) u_store (
    .clk, .we(g_we), .waddr(in_data.glyph_byte_addr), .wdata(in_data.data_byte),
    .raddr(g_ra), .rdata(g_rd)
  );

  logic acc_in, out_fire;
  assign in_stall = (state_r != S_IDLE);
  assign acc_in = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign g_we = acc_in && in_data.kind == psf_pkg::KIND_LOAD;
  assign t_ra = item_r.char_code;
  assign g_ra = base_r + {9'd0, y_r};

  // UTF-8 decode of an incoming table byte
  logic [7:0] b;
  logic       map_en;
  logic [15:0] map_code, acc_nxt, acc_shift;
  logic [1:0] pend_nxt;
  logic [8:0] gcnt_nxt;
  always_comb begin
    b = in_data.data_byte;
    map_en = 1'b0;
    map_code = 16'd0;
    acc_nxt = acc_r;
    pend_nxt = pend_r;
    gcnt_nxt = gcnt_r;
    acc_shift = {acc_r[9:0], b[5:0]};
    if (acc_in && in_data.kind == psf_pkg::KIND_TABLE) begin
      if (pend_r != 2'd0) begin
        acc_nxt = acc_shift;
        pend_nxt = pend_r - 2'd1;
        if (pend_r == 2'd1) begin
          map_en = 1'b1;
          map_code = acc_shift;
        end
      end else if (b == 8'hFF) begin
        gcnt_nxt = gcnt_r + 9'd1;
      end else if (!b[7]) begin
        map_en = 1'b1;
        map_code = {8'd0, b};
      end else if (!b[5]) begin
        acc_nxt = {11'd0, b[4:0]};
        pend_nxt = 2'd1;
      end else if (!b[4]) begin
        acc_nxt = {12'd0, b[3:0]};
        pend_nxt = 2'd2;
      end else if (!b[3]) begin
        acc_nxt = {13'd0, b[2:0]};
        pend_nxt = 2'd3;
      end else begin
        map_en = 1'b1;
      end
    end
  end

  always_comb begin
    if (state_r == S_CLEAR) begin
      t_we = 1'b1;
      t_wa = clr_r;
      t_wd = 9'd0;
    end else begin
      t_we = map_en;
      t_wa = map_code;
      t_wd = gcnt_r;
    end
  end

  logic [3:0] w_sat, h_sat;
  assign w_sat = (cfg.glyph_width > 4'(psf_pkg::MaxW)) ? 4'(psf_pkg::MaxW) : cfg.glyph_width;
  assign h_sat = (cfg.glyph_height > 4'(psf_pkg::MaxH)) ? 4'(psf_pkg::MaxH)
                                                       : cfg.glyph_height;
  logic [15:0] idx_raw;
  assign idx_raw = cfg.unicode_enable ? {7'd0, t_rd} : item_r.char_code;

  logic last_x, last_y;
  assign last_x = ({1'b0, x_r} == w_r - 4'd1);
  assign last_y = ({1'b0, y_r} == h_r - 4'd1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_r == 16'hFFFF) state_nxt = S_IDLE;
      S_IDLE: begin
        if (acc_in && in_data.kind == psf_pkg::KIND_DRAW) begin
          if (w_sat != 4'd0 && h_sat != 4'd0) state_nxt = S_TRD;
        end
      end
      S_TRD: state_nxt = S_IDX;
      S_IDX: state_nxt = S_MUL;
      S_MUL: state_nxt = S_ORG;
      S_ORG: state_nxt = S_ROW;
      S_ROW: state_nxt = S_PIX;
      S_PIX: begin
        if (out_fire && last_x) state_nxt = last_y ? S_IDLE : S_ROW;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= 16'd0;
      gcnt_r <= 9'd0;
      acc_r <= 16'd0;
      pend_r <= 2'd0;
      rowv_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 16'd1;
      gcnt_r <= gcnt_nxt;
      acc_r <= acc_nxt;
      pend_r <= pend_nxt;
      rowv_r <= (state_r == S_ROW);
    end
  end

  always_ff @(posedge clk) begin
    if (acc_in) begin
      item_r <= in_data;
      w_r <= w_sat;
      h_r <= h_sat;
    end
    if (state_r == S_IDX) begin
      if (idx_raw == 16'd0 || idx_raw >= {6'd0, cfg.glyph_count}) idx_r <= 10'd0;
      else idx_r <= idx_raw[9:0];
      // cy*h*line and cx*(w+1)*4 products
      p1_r <= 26'({8'd0, item_r.cell_y} * {12'd0, h_r});
      p2_r <= 26'({8'd0, item_r.cell_x} * ({1'b0, w_r} + 5'd1));
      y_r <= 3'd0;
    end
    if (state_r == S_MUL) begin
      base_r <= 12'(idx_r * {6'd0, cfg.bytes_per_glyph});
      p1_r <= 26'(p1_r[11:0] * cfg.line_bytes);
      p2_r <= {p2_r[23:0], 2'b00};
    end
    if (state_r == S_ORG) rowoff_r <= p1_r + p2_r;
    if (state_r == S_ROW) begin
      x_r <= 3'd0;
      off_r <= rowoff_r;
    end
    if (rowv_r) row_r <= g_rd;
    if (state_r == S_PIX && out_fire) begin
      x_r <= x_r + 3'd1;
      off_r <= off_r + 26'd4;
      if (last_x) begin
        y_r <= y_r + 3'd1;
        rowoff_r <= rowoff_r + {11'd0, cfg.line_bytes};
      end
    end
  end

  logic [7:0] row_cur;
  assign row_cur = rowv_r ? g_rd : row_r;
  assign out_valid = (state_r == S_PIX);
  assign out_data.pixel_offset = off_r;
  assign out_data.pixel_value = row_cur[3'd7 - x_r] ? cfg.fg_color : cfg.bg_color;
  assign out_data.last_pixel = last_x && last_y;

`ifndef ASSERT_OFF
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken during draw");
  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !acc_in) else $error("input during clear");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && out_data.last_pixel) |=> (state_r == S_IDLE))
    else $error("draw did not end on last pixel");
`endif
endmodule

FILE: tb/psf_render_checker.sv
`timescale 1ns / 1ps
module psf_render_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  psf_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  psf_pkg::out_word_t out_data,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [4:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  input  logic               cfg_pready,
  output int                 pending,
  output int                 fails
);
  import psf_pkg::*;

  cfg_t             regs;
  logic [7:0]       bitmap [GlyphDepth];
  logic [8:0]       glyph_of_code [TableDepth];
  logic [8:0]       glyph_ctr;
  logic [15:0]      accum;
  logic [1:0]       cont_left;
  out_word_t        pixel_q [$];

  task automatic report(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    fails++;
  endtask

  task automatic bind_code(input logic [15:0] code);
    glyph_of_code[code] = glyph_ctr;
  endtask

  task automatic decode_table_byte(input logic [7:0] b);
    if (cont_left != 2'd0) begin
      accum = {accum[9:0], 6'd0} + {10'd0, b[5:0]};
      cont_left--;
      if (cont_left == 2'd0) bind_code(accum);
    end else if (b == 8'hFF) begin
      glyph_ctr++;
    end else if (!b[7]) begin
      bind_code({8'd0, b});
    end else if (!b[5]) begin
      accum = {11'd0, b[4:0]};
      cont_left = 2'd1;
    end else if (!b[4]) begin
      accum = {12'd0, b[3:0]};
      cont_left = 2'd2;
    end else if (!b[3]) begin
      accum = {13'd0, b[2:0]};
      cont_left = 2'd3;
    end else begin
      bind_code(16'd0);
    end
  endtask

  task automatic predict_pixels(input in_word_t it);
    int unsigned w, h, idx, base, origin, off;
    logic [7:0]  row;
    out_word_t   px;
    w = (regs.glyph_width > MaxW) ? MaxW : regs.glyph_width;
    h = (regs.glyph_height > MaxH) ? MaxH : regs.glyph_height;
    if (w == 0 || h == 0) return;
    idx = regs.unicode_enable ? glyph_of_code[it.char_code] : it.char_code;
    if (idx == 0 || idx >= regs.glyph_count) idx = 0;
    base = idx * regs.bytes_per_glyph;
    origin = it.cell_y * h * regs.line_bytes + it.cell_x * (w + 1) * 4;
    for (int unsigned y = 0; y < h; y++) begin
      row = bitmap[12'((base + y) % GlyphDepth)];
      off = origin + y * regs.line_bytes;
      for (int unsigned x = 0; x < w; x++) begin
        px.pixel_offset = off[25:0];
        px.pixel_value = row[3'(7 - x)] ? regs.fg_color : regs.bg_color;
        px.last_pixel = (y == h - 1 && x == w - 1);
        pixel_q.push_back(px);
        off += 4;
      end
    end
  endtask

  initial fails = 0;

  always @(posedge clk) begin
    out_word_t exp_px;
    if (!rst_n) begin
      regs <= '{4'd8, 4'd8, 4'd8, 10'd256, 15'd800, 32'hFFFFFF, 32'd0, 1'b0};
      for (int i = 0; i < TableDepth; i++) glyph_of_code[i] = '0;
      for (int i = 0; i < GlyphDepth; i++) bitmap[i] = '0;
      glyph_ctr = '0;
      accum = '0;
      cont_left = '0;
      pixel_q.delete();
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (cfg_paddr[4:2])
          REG_WIDTH:  regs.glyph_width <= cfg_pwdata[3:0];
          REG_HEIGHT: regs.glyph_height <= cfg_pwdata[3:0];
          REG_BPG:    regs.bytes_per_glyph <= cfg_pwdata[3:0];
          REG_COUNT:  regs.glyph_count <= cfg_pwdata[9:0];
          REG_LINE:   regs.line_bytes <= cfg_pwdata[14:0];
          REG_FG:     regs.fg_color <= cfg_pwdata;
          REG_BG:     regs.bg_color <= cfg_pwdata;
          REG_UNI:    regs.unicode_enable <= cfg_pwdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        case (in_data.kind)
          KIND_LOAD:  bitmap[in_data.glyph_byte_addr] = in_data.data_byte;
          KIND_TABLE: decode_table_byte(in_data.data_byte);
          KIND_DRAW:  predict_pixels(in_data);
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pixel_q.size() == 0) begin
          report($sformatf("unexpected pixel word off=%h", out_data.pixel_offset));
        end else begin
          exp_px = pixel_q.pop_front();
          if (out_data.pixel_offset !== exp_px.pixel_offset)
            report($sformatf("pixel_offset %h, want %h", out_data.pixel_offset,
                             exp_px.pixel_offset));
          if (out_data.pixel_value !== exp_px.pixel_value)
            report($sformatf("pixel_value %h, want %h", out_data.pixel_value,
                             exp_px.pixel_value));
          if (out_data.last_pixel !== exp_px.last_pixel)
            report($sformatf("last_pixel %b, want %b", out_data.last_pixel,
                             exp_px.last_pixel));
        end
      end
    end
    pending <= pixel_q.size();
  end
endmodule

FILE: tb/psf_glyph_renderer_top_tb.sv
`timescale 1ns / 1ps
module psf_glyph_renderer_top_tb;
  import psf_pkg::*;

  localparam int StallLimit = 400000;
  localparam int DrainCycles = 20;
  localparam int FillBytes = 128;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_word_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_word_t   out_data;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          pending;
  int          fails;
  int          gap_pct = 0;
  int          stall_pct = 0;
  int          quiet_cycles = 0;
  logic [15:0] bound_codes [$];
  logic        uni_on = 1'b0;
  int          glyphs = 256;

  psf_glyph_renderer_top dut (.*);

  psf_render_checker chk (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic send_word(input in_word_t w);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_table(input logic [7:0] b);
    in_word_t w;
    w = in_word_t'(54'({$urandom, $urandom}));
    w.kind = KIND_TABLE;
    w.data_byte = b;
    send_word(w);
  endtask

  task automatic send_load(input logic [11:0] a, input logic [7:0] d);
    in_word_t w;
    w = in_word_t'(54'({$urandom, $urandom}));
    w.kind = KIND_LOAD;
    w.glyph_byte_addr = a;
    w.data_byte = d;
    send_word(w);
  endtask

  task automatic send_draw(input logic [15:0] ch, input logic [7:0] cx, input logic [7:0] cy);
    in_word_t w;
    w = in_word_t'(54'({$urandom, $urandom}));
    w.kind = KIND_DRAW;
    w.char_code = ch;
    w.cell_x = cx;
    w.cell_y = cy;
    send_word(w);
  endtask

  task automatic quiesce;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_font(input int w, input int h, input int bpg, input int cnt,
                          input int lb, input logic [31:0] fg, input logic [31:0] bg,
                          input logic uni);
    quiesce();
    cfg_write(REG_WIDTH, w);
    cfg_write(REG_HEIGHT, h);
    cfg_write(REG_BPG, bpg);
    cfg_write(REG_COUNT, cnt);
    cfg_write(REG_LINE, lb);
    cfg_write(REG_FG, fg);
    cfg_write(REG_BG, bg);
    cfg_write(REG_UNI, {31'd0, uni});
    uni_on = uni;
    glyphs = cnt;
  endtask

  // UTF-8 sequence of random length and content, with well-formed lead and continuation bits
  task automatic send_utf8;
    logic [20:0] v;
    v = 21'($urandom);
    case ($urandom_range(3))
      0: begin
        send_table({1'b0, v[6:0]});
        bound_codes.push_back({9'd0, v[6:0]});
      end
      1: begin
        send_table({3'b110, v[10:6]});
        send_table({2'b10, v[5:0]});
        bound_codes.push_back({5'd0, v[10:0]});
      end
      2: begin
        send_table({4'b1110, v[15:12]});
        send_table({2'b10, v[11:6]});
        send_table({2'b10, v[5:0]});
        bound_codes.push_back(v[15:0]);
      end
      default: begin
        send_table({5'b11110, v[20:18]});
        send_table({2'b10, v[17:12]});
        send_table({2'b10, v[11:6]});
        send_table({2'b10, v[5:0]});
        bound_codes.push_back(v[15:0]);
      end
    endcase
  endtask

  task automatic random_phase(input int n);
    logic [15:0] ch;
    int          pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 20) begin
        send_load(12'($urandom), 8'($urandom));
      end else if (pick < 45) begin
        send_utf8();
      end else if (pick < 50) begin
        send_table(8'hFF);
      end else if (pick < 55) begin
        send_table(8'($urandom)); // noise, may leave a sequence half done
      end else begin
        if (uni_on && bound_codes.size() != 0 && $urandom_range(9) < 7)
          ch = bound_codes[$urandom_range(bound_codes.size() - 1)];
        else if ($urandom_range(9) < 7)
          ch = 16'($urandom_range(glyphs));
        else
          ch = 16'($urandom);
        send_draw(ch, 8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    in_word_t odd;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_pct = 6;
    stall_pct = 54;

    // fill the low store bytes, the only ones the fonts below can reach
    for (int a = 0; a < FillBytes; a++) send_load(12'(a), 8'($urandom));

    set_font(8, 8, 8, 16, 800, 32'hFFFFFF, 32'h0, 1'b0);
    send_load(12'hFFF, 8'hFF);
    send_load(12'h000, 8'h00);
    send_draw(16'd0, 8'd0, 8'd0);
    send_draw(16'd255, 8'hFF, 8'hFF);
    send_draw(16'd256, 8'd3, 8'd4);      // index past glyph count
    send_draw(16'hFFFF, 8'd1, 8'd1);
    send_table(8'h41);                   // single byte
    send_table(8'hFF);                   // next glyph
    send_table(8'hC3); send_table(8'hA9);
    send_table(8'hE2); send_table(8'h82); send_table(8'hAC);
    send_table(8'hF0); send_table(8'h9F); send_table(8'h98); send_table(8'h80);
    send_table(8'h85); send_table(8'hFF); // continuation lead, 0xFF as continuation
    send_table(8'hF8);                   // bad lead maps code zero
    send_table(8'hFE);
    odd = '0;
    odd.kind = KIND_SPARE;               // unused kind
    send_word(odd);
    random_phase(30);

    set_font(1, 1, 1, 1, 4, 32'h0, 32'hFFFFFFFF, 1'b1);
    send_draw(16'h0041, 8'd0, 8'd0);
    send_draw(16'h00E9, 8'hFF, 8'hFF);
    send_draw(16'h20AC, 8'd7, 8'd9);
    random_phase(30);

    gap_pct = 54;
    stall_pct = 6;
    set_font(8, 8, 8, 12, 16384, $urandom, $urandom, 1'b1);
    send_draw(16'h20AC, 8'hFF, 8'hFF);
    send_draw(16'h0041, 8'd0, 8'd0);
    random_phase(40);

    set_font(3, 5, 6, 16, 1000, $urandom, $urandom, 1'b0);
    random_phase(40);

    gap_pct = 0;
    stall_pct = 0;
    set_font(15, 15, 15, 8, 3333, $urandom, $urandom, 1'b1); // oversized geometry
    random_phase(40);

    set_font(0, 4, 3, 100, 64, $urandom, $urandom, 1'b0); // zero width: no pixels
    random_phase(10);
    set_font(5, 7, 0, 1023, 777, $urandom, $urandom, 1'b0);
    random_phase(30);

    quiesce();
    if (fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

FILE: psf_glyph_renderer_top.f
rtl/core/psf_pkg.sv
rtl/core/psf_ram.sv
rtl/core/psf_regs.sv
rtl/core/psf_glyph_renderer_top.sv
tb/psf_render_checker.sv
tb/psf_glyph_renderer_top_tb.sv
